// ===== hdl/ihg_pkg.sv =====
// ihg_pkg: types, constants and header word positions shared by the
// ipv4 header generator modules; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ihg_pkg;

    // default payload limit in bytes
    localparam int MTU_DEFAULT = 1480;

    // config port geometry
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ADDR   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_ADDR = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TTL_VALUE    = 8'd3;

    localparam logic [7:0] TTL_RESET = 8'd64;

    // fixed header contents
    localparam logic [15:0] HDR_BYTES   = 16'd20;
    localparam logic [15:0] VER_IHL_TOS = 16'h4500;
    localparam logic [15:0] ZERO_WORD   = 16'h0000;

    // word positions within the header
    localparam int IDX_W = 4;
    localparam logic [IDX_W-1:0] WPOS_VER_TOS   = 4'd0;
    localparam logic [IDX_W-1:0] WPOS_TOT_LEN   = 4'd1;
    localparam logic [IDX_W-1:0] WPOS_IDENT     = 4'd2;
    localparam logic [IDX_W-1:0] WPOS_FRAG      = 4'd3;
    localparam logic [IDX_W-1:0] WPOS_TTL_PROTO = 4'd4;
    localparam logic [IDX_W-1:0] WPOS_CSUM      = 4'd5;
    localparam logic [IDX_W-1:0] WPOS_SRC_HI    = 4'd6;
    localparam logic [IDX_W-1:0] WPOS_SRC_LO    = 4'd7;
    localparam logic [IDX_W-1:0] WPOS_DST_HI    = 4'd8;
    localparam logic [IDX_W-1:0] WPOS_DST_LO    = 4'd9;
    localparam logic [IDX_W-1:0] WPOS_LAST      = WPOS_DST_LO;

    // config register set seen by the front
    typedef struct packed {
        logic [31:0] local_addr;
        logic [31:0] subnet_mask;
        logic [31:0] gateway_addr;
        logic [7:0]  ttl_value;
    } t_cfg;

    // one fully built header waiting to be sent
    typedef struct packed {
        logic [15:0] pkt_len;
        logic [15:0] pkt_id;
        logic [15:0] ttl_proto;
        logic [15:0] csum;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [31:0] hop_addr;
    } t_hdr_entry;

    // front status for monitoring
    typedef struct packed {
        logic [15:0] pkt_id;
        logic        stage_a_valid;
        logic        stage_b_valid;
    } t_front_status;

endpackage

`default_nettype wire

// ===== hdl/ihg_front.sv =====
// ihg_front: accepts send requests, drops them when unconfigured, and
// builds the header fields and checksum in two stages; uses ihg_pkg
`timescale 1ns / 1ps
`default_nettype none

module ihg_front #(
    parameter int MTU_BYTES = ihg_pkg::MTU_DEFAULT
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire ihg_pkg::t_cfg      i_cfg,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire [31:0]              i_dest_addr,
    input  wire [7:0]               i_proto_num,
    input  wire [15:0]              i_payload_len,
    output logic                    o_q_valid,
    input  wire                     i_q_ready,
    output ihg_pkg::t_hdr_entry     o_entry,
    output ihg_pkg::t_front_status  o_status
);
    import ihg_pkg::*;

    localparam logic [15:0] MTU_LIMIT = 16'(MTU_BYTES);

    logic        r_a_valid;
    logic [15:0] r_a_len;
    logic [15:0] r_a_id;
    logic [15:0] r_a_ttl_proto;
    logic [31:0] r_a_src;
    logic [31:0] r_a_dst;
    logic [31:0] r_a_hop;
    logic [18:0] r_a_part;
    logic [15:0] r_pkt_id;

    logic        r_b_valid;
    t_hdr_entry  r_b_entry;

    logic        w_a_ready;
    logic        w_b_ready;
    logic        w_accept;
    logic        w_load_a;
    logic [15:0] w_plen_sat;
    logic [15:0] w_ttl_proto;
    logic [31:0] w_hop;
    logic [18:0] w_part;
    logic [19:0] w_sum;
    logic [16:0] w_fold1;
    logic [15:0] w_fold2;

    // stall chain from the queue back to the input
    assign w_b_ready = !r_b_valid || i_q_ready;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign o_ready   = w_a_ready;
    assign w_accept  = i_valid && w_a_ready;
    assign w_load_a  = w_accept && (i_cfg.local_addr != 32'd0);

    // length clamp, next hop and partial checksum of the address words
    always_comb begin
        w_plen_sat  = (i_payload_len > MTU_LIMIT) ? MTU_LIMIT : i_payload_len;
        w_ttl_proto = {i_cfg.ttl_value, i_proto_num};
        w_hop       = ((i_dest_addr & i_cfg.subnet_mask) ==
                       (i_cfg.local_addr & i_cfg.subnet_mask)) ?
                      i_dest_addr : i_cfg.gateway_addr;
        w_part      = 19'(i_cfg.local_addr[31:16]) + 19'(i_cfg.local_addr[15:0]) +
                      19'(i_dest_addr[31:16]) + 19'(i_dest_addr[15:0]) +
                      19'(w_ttl_proto);
    end

    // stage a control and identification counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_pkt_id  <= 16'd0;
        end else begin
            if (w_a_ready) begin
                r_a_valid <= w_load_a;
            end
            if (w_load_a) begin
                r_pkt_id <= r_pkt_id + 16'd1;
            end
        end
    end

    // stage a payload
    always_ff @(posedge i_clk) begin
        if (w_load_a) begin
            r_a_len       <= HDR_BYTES + w_plen_sat;
            r_a_id        <= r_pkt_id;
            r_a_ttl_proto <= w_ttl_proto;
            r_a_src       <= i_cfg.local_addr;
            r_a_dst       <= i_dest_addr;
            r_a_hop       <= w_hop;
            r_a_part      <= w_part;
        end
    end

    // remaining sum terms and carry fold
    always_comb begin
        w_sum   = 20'(r_a_part) + 20'(VER_IHL_TOS) + 20'(r_a_len) + 20'(r_a_id);
        w_fold1 = 17'(w_sum[15:0]) + 17'(w_sum[19:16]);
        w_fold2 = w_fold1[15:0] + 16'(w_fold1[16]);
    end

    // stage b control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    // stage b payload
    always_ff @(posedge i_clk) begin
        if (r_a_valid && w_b_ready) begin
            r_b_entry.pkt_len   <= r_a_len;
            r_b_entry.pkt_id    <= r_a_id;
            r_b_entry.ttl_proto <= r_a_ttl_proto;
            r_b_entry.csum      <= ~w_fold2;
            r_b_entry.src_addr  <= r_a_src;
            r_b_entry.dst_addr  <= r_a_dst;
            r_b_entry.hop_addr  <= r_a_hop;
        end
    end

    assign o_q_valid = r_b_valid;
    assign o_entry   = r_b_entry;

    assign o_status.pkt_id        = r_pkt_id;
    assign o_status.stage_a_valid = r_a_valid;
    assign o_status.stage_b_valid = r_b_valid;

endmodule

`default_nettype wire

// ===== hdl/ihg_queue.sv =====
// ihg_queue: two-entry queue of built headers between front and back
// uses ihg_pkg for the entry type
`timescale 1ns / 1ps
`default_nettype none

module ihg_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wire ihg_pkg::t_hdr_entry i_entry,
    output logic                 o_full,
    input  wire                  i_pop,
    output logic                 o_valid,
    output ihg_pkg::t_hdr_entry  o_entry
);
    import ihg_pkg::*;

    t_hdr_entry  r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        w_push;
    logic        w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;
    assign o_entry = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(w_push) - 2'(w_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ihg_back.sv =====
// ihg_back: sends one queued header as ten 16-bit words with the next hop
// uses ihg_pkg for the entry type and word positions
`timescale 1ns / 1ps
`default_nettype none

module ihg_back (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_q_valid,
    input  wire ihg_pkg::t_hdr_entry i_entry,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire                      i_ready,
    output logic [15:0]              o_header_word,
    output logic [ihg_pkg::IDX_W-1:0] o_word_index,
    output logic [31:0]              o_hop_addr,
    output logic                     o_last_word
);
    import ihg_pkg::*;

    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    t_hdr_entry       r_entry;
    logic             w_adv;
    logic             w_done;
    logic             w_load;

    assign w_adv  = r_busy && i_ready;
    assign w_done = w_adv && (r_idx == WPOS_LAST);
    assign w_load = i_q_valid && (!r_busy || w_done);
    assign o_pop  = w_load;

    // word counter, next header is loaded as the last word leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= WPOS_VER_TOS;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_idx  <= WPOS_VER_TOS;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end else if (w_adv) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    // header being sent
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_entry <= i_entry;
        end
    end

    // word select
    always_comb begin
        case (r_idx)
            WPOS_VER_TOS:   o_header_word = VER_IHL_TOS;
            WPOS_TOT_LEN:   o_header_word = r_entry.pkt_len;
            WPOS_IDENT:     o_header_word = r_entry.pkt_id;
            WPOS_FRAG:      o_header_word = ZERO_WORD;
            WPOS_TTL_PROTO: o_header_word = r_entry.ttl_proto;
            WPOS_CSUM:      o_header_word = r_entry.csum;
            WPOS_SRC_HI:    o_header_word = r_entry.src_addr[31:16];
            WPOS_SRC_LO:    o_header_word = r_entry.src_addr[15:0];
            WPOS_DST_HI:    o_header_word = r_entry.dst_addr[31:16];
            WPOS_DST_LO:    o_header_word = r_entry.dst_addr[15:0];
            default:        o_header_word = ZERO_WORD;
        endcase
    end

    assign o_valid      = r_busy;
    assign o_word_index = r_idx;
    assign o_hop_addr   = r_entry.hop_addr;
    assign o_last_word  = (r_idx == WPOS_LAST);

endmodule

`default_nettype wire

// ===== hdl/ipv4_header_generator.sv =====
// ipv4_header_generator: top level with config registers, front, queue
// and back; uses ihg_pkg, ihg_front, ihg_queue, ihg_back
`timescale 1ns / 1ps
`default_nettype none

// Builds a 20-byte IPv4 header per send request and streams it as ten
// big-endian 16-bit words (word_index 0 to 9, tlast on the tenth), each
// tagged with the next hop: the destination when it shares the local
// subnet, else the gateway. Payload length is clamped to MTU_BYTES before
// the total length is formed; the checksum is the folded ones-complement
// sum. Requests arriving while local_addr is zero are taken and dropped
// without output and do not advance the identification counter. Words
// leave one per cycle while m_axis_tready is high. Requests are taken
// back to back while s_axis_tready is high and pass a two-stage front
// (stage a, stage b), a two-entry queue and the back's header register
// before the first word; successive headers follow with no gap. Config
// writes are always ready and must be made only while the block is idle.
module ipv4_header_generator #(
    parameter int MTU_BYTES = ihg_pkg::MTU_DEFAULT
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // config write channel
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [ihg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [ihg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request stream
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire [55:0]                     s_axis_tdata,   // dest_addr, proto_num, payload_len
    // header word stream
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [55:0]                    m_axis_tdata,   // header_word, word_index, hop_addr, pad
    output logic                           m_axis_tlast    // last_word
);
    import ihg_pkg::*;

    t_cfg            r_cfg;
    t_hdr_entry      w_front_entry;
    t_hdr_entry      w_q_entry;
    t_front_status   w_status;
    logic            w_front_valid;
    logic            w_q_full;
    logic            w_q_valid;
    logic            w_pop;
    logic [15:0]     w_header_word;
    logic [IDX_W-1:0] w_word_index;
    logic [31:0]     w_hop_addr;

    // config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.local_addr   <= 32'd0;
            r_cfg.subnet_mask  <= 32'd0;
            r_cfg.gateway_addr <= 32'd0;
            r_cfg.ttl_value    <= TTL_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LOCAL_ADDR:   r_cfg.local_addr   <= i_cfg_data;
                REG_SUBNET_MASK:  r_cfg.subnet_mask  <= i_cfg_data;
                REG_GATEWAY_ADDR: r_cfg.gateway_addr <= i_cfg_data;
                REG_TTL_VALUE:    r_cfg.ttl_value    <= i_cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // request intake and header build
    ihg_front #(
        .MTU_BYTES (MTU_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_dest_addr   (s_axis_tdata[31:0]),
        .i_proto_num   (s_axis_tdata[39:32]),
        .i_payload_len (s_axis_tdata[55:40]),
        .o_q_valid     (w_front_valid),
        .i_q_ready     (!w_q_full),
        .o_entry       (w_front_entry),
        .o_status      (w_status)
    );

    // header queue
    ihg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_entry (w_front_entry),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry)
    );

    // word serializer
    ihg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_entry       (w_q_entry),
        .o_pop         (w_pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_header_word (w_header_word),
        .o_word_index  (w_word_index),
        .o_hop_addr    (w_hop_addr),
        .o_last_word   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, w_hop_addr, w_word_index, w_header_word};

    // checks

    // a dropped request leaves the identification counter alone
    a_drop_keeps_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (r_cfg.local_addr == 32'd0)
        |=> $stable(w_status.pkt_id))
        else $error("identification advanced on a dropped request");

    // front never offers a header to a full queue without being held
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_front_valid && w_q_full |=> w_front_valid && $stable(w_front_entry))
        else $error("header lost at the queue");

    // words inside a header come out in order without a break
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
        |=> m_axis_tvalid && (w_word_index == $past(w_word_index) + 4'd1))
        else $error("header word sequence broken");

    // tlast marks exactly the final word position
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (w_word_index == WPOS_LAST)))
        else $error("tlast not on the final word");

endmodule

`default_nettype wire
